// ===== hdl/dsi64_pkg.sv =====
// Shared types and constants for the checked ASCII decimal to int64 converter.
package dsi64_pkg;

    localparam int unsigned DEF_MAX_DIGITS = 19;
    localparam int unsigned CHAR_W         = 8;
    localparam int unsigned CNT_W          = 5;
    localparam int unsigned MAG_W          = 64;

    localparam logic [CNT_W-1:0]  CNT_SAT    = CNT_W'(20);
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } in_word_t;

    typedef struct packed {
        logic                    is_valid;
        logic signed [MAG_W-1:0] number;
    } out_word_t;

endpackage

// ===== hdl/dsi64_in_stage.sv =====
// Input register: holds one accepted word until the parser consumes it.
module dsi64_in_stage
    import dsi64_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_data,
    input  logic     take,
    output logic     hold_valid,
    output in_word_t hold_data
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t data_reg;

    assign in_ready   = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

// ===== hdl/dsi64_parse.sv =====
// Parser state and per-character update; forms the result on an end marker.
module dsi64_parse
    import dsi64_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = DEF_MAX_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  in_word_t  word,
    output out_word_t res
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    phase_t            phase_reg,    phase_next;
    logic              neg_reg,      neg_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [MAG_W-1:0]  mag_reg,      mag_next;
    logic              bad_reg,      bad_next;

    logic              is_digit;
    logic [3:0]        digit_val;
    logic [CNT_W-1:0]  cnt_inc;
    logic              in_range;
    logic              ok;

    assign is_digit  = word.char_code inside {[CH_ZERO:CH_NINE]};
    assign digit_val = 4'(word.char_code - CH_ZERO);
    assign cnt_inc   = (cnt_reg < CNT_SAT) ? cnt_reg + CNT_W'(1) : cnt_reg;

    // Negative side may reach 2^63 exactly.
    assign in_range = !mag_reg[MAG_W-1] || (neg_reg && (mag_reg[MAG_W-2:0] == '0));
    assign ok       = !bad_reg && (phase_reg == PH_DIGITS) && (cnt_reg <= MAX_CNT)
                      && in_range;

    always_comb
    begin
        res.is_valid = ok;
        if (!ok)
        begin
            res.number = '0;
        end
        else if (neg_reg)
        begin
            res.number = -mag_reg;
        end
        else
        begin
            res.number = mag_reg;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        bad_next   = bad_reg;
        if (go)
        begin
            if (word.end_of_text)
            begin
                phase_next = PH_START;
                neg_next   = 1'b0;
                cnt_next   = '0;
                mag_next   = '0;
                bad_next   = 1'b0;
            end
            else if (!bad_reg)
            begin
                if (!is_digit)
                begin
                    if ((phase_reg == PH_START)
                        && (word.char_code == CH_PLUS || word.char_code == CH_MINUS))
                    begin
                        neg_next   = (word.char_code == CH_MINUS);
                        phase_next = PH_SIGN;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_DIGITS;
                    // leading zeros leave count and magnitude alone
                    if (!(word.char_code == CH_ZERO && cnt_reg == '0))
                    begin
                        cnt_next = cnt_inc;
                        if (cnt_inc <= MAX_CNT)
                        begin
                            mag_next = (mag_reg << 3) + (mag_reg << 1)
                                       + MAG_W'(digit_val);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            mag_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
            mag_reg   <= mag_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

// ===== hdl/dsi64_out_stage.sv =====
// Result register: holds one result word until the consumer takes it.
module dsi64_out_stage
    import dsi64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_word_t load_data,
    output logic      free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== hdl/decimal_string_to_int64_checked.sv =====
// Top level of the checked ASCII decimal string to signed 64-bit converter.
//
//   channel   direction  handshake             word
//   in        input      in_valid / in_ready   in_data  (char_code, end_of_text)
//   out       output     out_valid / out_ready out_data (is_valid, number)
//
// One word per cycle is taken unless the input stalls. Each word is held in the input
// register, and the parser consumes it from there (shift-add times ten plus digit).
// An end marker's result is loaded into the result register once that register is
// free, and the consumer takes it from the result register.
// Reset (rst_n low) clears both stage valids and returns the parser to string start.
// Characters never wait in the input register. Input stalls only while an end marker
// waits behind a full result register that is not being taken.
module decimal_string_to_int64_checked
    import dsi64_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = DEF_MAX_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic      hold_valid;
    in_word_t  hold_data;
    logic      free;
    logic      go;
    logic      load;
    out_word_t res;

    assign go   = hold_valid && (!hold_data.end_of_text || free);
    assign load = go && hold_data.end_of_text;

    dsi64_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .take       (go),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    dsi64_parse #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .word  (hold_data),
        .res   (res)
    );

    dsi64_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (res),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // input stalls only behind a blocked end marker
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (hold_valid && hold_data.end_of_text && out_valid && !out_ready))
        else $error("input stalled without a blocked end marker");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result register overwritten");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.is_valid) |-> (out_data.number == '0))
        else $error("invalid result carries nonzero number");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("loaded result not presented");

endmodule

// ===== verif/decimal_string_to_int64_checked_test.sv =====
// Testbench for the checked ASCII decimal to int64 converter: directed and random strings.
module decimal_string_to_int64_checked_test
    import dsi64_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_WORDS = 500;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t text_t[$];

    // Tracks the parser state as words are accepted and holds the results still due.
    class conv_scoreboard;
        phase_t           phase;
        bit               neg;
        logic [CNT_W-1:0] digit_count;
        logic [MAG_W-1:0] mag;
        bit               bad;
        out_word_t        pending_q[$];
        int               errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            phase       = PH_START;
            neg         = 1'b0;
            digit_count = '0;
            mag         = '0;
            bad         = 1'b0;
        endfunction

        function void note_word(in_word_t w);
            char_t            c;
            logic [MAG_W-1:0] lim;
            out_word_t        r;
            c = w.char_code;
            if (!w.end_of_text)
            begin
                if (!bad)
                begin
                    if (!(c >= CH_ZERO && c <= CH_NINE))
                    begin
                        if (phase == PH_START && (c == CH_PLUS || c == CH_MINUS))
                        begin
                            neg   = (c == CH_MINUS);
                            phase = PH_SIGN;
                        end
                        else
                            bad = 1'b1;
                    end
                    else
                    begin
                        phase = PH_DIGITS;
                        // leading zeros leave count and magnitude alone
                        if (!(c == CH_ZERO && digit_count == '0))
                        begin
                            if (digit_count < CNT_SAT)
                                digit_count = digit_count + 1'b1;
                            if (digit_count <= DEF_MAX_DIGITS)
                                mag = mag * 64'd10 + MAG_W'(c - CH_ZERO);
                        end
                    end
                end
            end
            else
            begin
                lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                r.is_valid = !bad && phase == PH_DIGITS && digit_count <= DEF_MAX_DIGITS
                             && mag <= lim;
                if (r.is_valid)
                    r.number = neg ? (64'd0 - mag) : mag;
                else
                    r.number = '0;
                pending_q.push_back(r);
                clear();
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result is_valid=%0b number=%0d", $time,
                         got.is_valid, $signed(got.number));
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.is_valid !== want.is_valid)
            begin
                $display("%0t: is_valid mismatch expected %0b actual %0b", $time,
                         want.is_valid, got.is_valid);
                errors++;
            end
            if (got.number !== want.number)
            begin
                $display("%0t: number mismatch expected %0d actual %0d", $time,
                         $signed(want.number), $signed(got.number));
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    conv_scoreboard sb = new();
    int             idle_mode;  // 0 none, 1 sender, 2 receiver, 3 both
    int unsigned    cycle_count;

    decimal_string_to_int64_checked u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int send_idle_pct();
        return (idle_mode == 1) ? 66 : (idle_mode == 3) ? 21 : 0;
    endfunction

    function automatic int recv_stall_pct();
        return (idle_mode == 2) ? 66 : (idle_mode == 3) ? 21 : 0;
    endfunction

    always @(negedge clk)
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct());

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(w);
        @(negedge clk);
    endtask

    task automatic send_text(text_t s);
        foreach (s[i])
            send_word(in_word_t'{char_code: s[i], end_of_text: 1'b0});
        // terminator carries a junk character that must be ignored
        send_word(in_word_t'{char_code: char_t'($urandom_range(0, 255)),
                             end_of_text: 1'b1});
    endtask

    function automatic text_t to_text(string t);
        text_t s;
        for (int i = 0; i < t.len(); i++)
            s.push_back(char_t'(t[i]));
        return s;
    endfunction

    function automatic text_t decimal_text(logic [MAG_W-1:0] v);
        text_t s;
        do
        begin
            s.push_front(CH_ZERO + char_t'(v % 64'd10));
            v = v / 64'd10;
        end
        while (v != 0);
        return s;
    endfunction

    function automatic text_t make_random_text();
        text_t s;
        text_t num;
        int    kind;
        int    n;
        kind = $urandom_range(0, 99);
        if (kind < 90)
        begin
            case ($urandom_range(0, 2))
                1: s.push_back(CH_PLUS);
                2: s.push_back(CH_MINUS);
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) s.push_back(CH_ZERO);
            if (kind < 60)
            begin
                n = ($urandom_range(0, 99) < 15) ? $urandom_range(15, 22)
                                                 : $urandom_range(1, 6);
                repeat (n) s.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
            end
            else if (kind < 75)
            begin
                // magnitudes around the signed 64-bit bounds
                num = decimal_text(64'h8000_0000_0000_0000 - 64'd3
                                   + 64'($urandom_range(0, 6)));
                s = {s, num};
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    s.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
                if ($urandom_range(0, 3) == 0)
                    s.insert($urandom_range(0, s.size()),
                             $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                else
                    s.insert($urandom_range(0, s.size()), char_t'($urandom_range(0, 255)));
            end
        end
        else
        begin
            repeat ($urandom_range(0, 5))
            begin
                case ($urandom_range(0, 2))
                    0: s.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
                    1: s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    default: s.push_back(char_t'($urandom_range(0, 255)));
                endcase
            end
        end
        return s;
    endfunction

    string directed_texts[] = '{
        "", "+", "-", "0", "-0", "+0", "007",
        "9223372036854775807", "-9223372036854775808",
        "+9223372036854775808", "-9223372036854775809",
        "9999999999999999999", "0000000000000000000000001",
        "123456789012345678901234", "+-1", "12-3", "1 2", "12a4"
    };

    initial
    begin
        text_t       txt;
        int unsigned rand_words;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        idle_mode   = 0;
        cycle_count = 0;
        rand_words  = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_texts[i])
            send_text(to_text(directed_texts[i]));
        // NUL is just a bad character, and the top code must be rejected too
        send_text('{8'h00, CH_ZERO + 8'd1});
        send_text('{CH_ZERO + 8'd5, 8'hFF});

        while (rand_words < RANDOM_WORDS)
        begin
            idle_mode = (rand_words * 4) / RANDOM_WORDS;
            txt = make_random_text();
            send_text(txt);
            rand_words += txt.size() + 1;
        end
        in_valid = 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
